// ===== src/ufv_pkg.sv =====
package ufv_pkg;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_DELIM     = 3'd1;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd2;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd3;
    localparam logic [2:0] ERR_OVERLONG  = 3'd4;
    localparam logic [2:0] ERR_SURROGATE = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd6;

    localparam logic [7:0] UNIT_SEP   = 8'h1F;
    localparam logic [7:0] RECORD_SEP = 8'h1E;
    localparam logic [7:0] COMMA      = 8'h2C;
    localparam logic [7:0] EQUALS     = 8'h3D;

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO_BYTE = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [20:0] MIN_FOUR     = 21'h010000;

    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] accum;
        logic [1:0]  seq_len;
        logic        delim;
        logic [2:0]  utf_err;
    } ufv_state_t;

    localparam ufv_state_t STATE_CLEAR = '0;

    function automatic logic is_delim(input logic [7:0] b);
        is_delim = (b == UNIT_SEP) || (b == RECORD_SEP) || (b == COMMA) || (b == EQUALS);
    endfunction

    function automatic logic [20:0] min_for_len(input logic [1:0] n);
        logic [20:0] m;
        unique case (n)
            2'd1:    m = MIN_TWO_BYTE;
            2'd2:    m = MIN_THREE;
            default: m = MIN_FOUR;
        endcase
        min_for_len = m;
    endfunction

endpackage

// ===== src/ufv_decode.sv =====
module ufv_decode
    import ufv_pkg::*;
(
    input  ufv_state_t state,
    input  logic [7:0] data_byte,
    input  logic       is_end,
    output ufv_state_t state_next,
    output logic [2:0] verdict
);

    logic [20:0] cp;

    always_comb
    begin
        state_next = state;
        cp         = {state.accum[14:0], data_byte[5:0]};
        verdict    = ERR_NONE;

        if (is_end)
        begin
            priority if (state.delim)
                verdict = ERR_DELIM;
            else if (state.utf_err != ERR_NONE)
                verdict = state.utf_err;
            else if (state.pending != 2'd0)
                verdict = ERR_BAD_CONT;
            else
                verdict = ERR_NONE;
            state_next = STATE_CLEAR;
        end
        else
        begin
            if (is_delim(data_byte))
                state_next.delim = 1'b1;

            if (state.utf_err == ERR_NONE)
            begin
                if (state.pending != 2'd0)
                begin
                    if (data_byte[7:6] != 2'b10)
                    begin
                        state_next.utf_err = ERR_BAD_CONT;
                        state_next.pending = 2'd0;
                    end
                    else if (state.pending == 2'd1)
                    begin
                        // sequence complete
                        priority if (cp < min_for_len(state.seq_len))
                            state_next.utf_err = ERR_OVERLONG;
                        else if (cp > CP_MAX)
                            state_next.utf_err = ERR_TOO_LARGE;
                        else if (cp >= SURR_LOW && cp <= SURR_HIGH)
                            state_next.utf_err = ERR_SURROGATE;
                        else
                            state_next.utf_err = ERR_NONE;
                        state_next.pending = 2'd0;
                        state_next.accum   = '0;
                        state_next.seq_len = 2'd0;
                    end
                    else
                    begin
                        state_next.pending = state.pending - 2'd1;
                        state_next.accum   = cp;
                    end
                end
                else
                begin
                    priority if (data_byte[7] == 1'b0)
                    begin
                        state_next.pending = 2'd0;
                    end
                    else if (data_byte[7:5] == 3'b110)
                    begin
                        state_next.seq_len = 2'd1;
                        state_next.pending = 2'd1;
                        state_next.accum   = {16'd0, data_byte[4:0]};
                    end
                    else if (data_byte[7:4] == 4'b1110)
                    begin
                        state_next.seq_len = 2'd2;
                        state_next.pending = 2'd2;
                        state_next.accum   = {17'd0, data_byte[3:0]};
                    end
                    else if (data_byte[7:3] == 5'b11110)
                    begin
                        state_next.seq_len = 2'd3;
                        state_next.pending = 2'd3;
                        state_next.accum   = {18'd0, data_byte[2:0]};
                    end
                    else
                    begin
                        state_next.utf_err = ERR_BAD_LEAD;
                    end
                end
            end
        end
    end

endmodule

// ===== src/ufv_out_stage.sv =====
module ufv_out_stage
    import ufv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [2:0] verdict,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       field_valid,
    output logic [2:0] error_code,
    output logic       can_load
);

    logic       valid_reg;
    logic       valid_next;
    logic       field_valid_reg;
    logic [2:0] error_code_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            field_valid_reg <= (verdict == ERR_NONE);
            error_code_reg  <= verdict;
        end
    end

    assign out_valid   = valid_reg;
    assign field_valid = field_valid_reg;
    assign error_code  = error_code_reg;

endmodule

// ===== src/utf8_field_validator_top.sv =====
// Strict UTF-8 field checker. Bytes of a field arrive one item per cycle with is_end low;
// an item with is_end high closes the field and yields one verdict (field_valid,
// error_code), while byte items yield nothing. A byte or end item can be accepted every
// cycle unless the input register stalls; an end item waits in the input register and its
// verdict in the output register. The input register stalls only when it holds an end
// item and the output register holds a stalled verdict. Delimiters (0x1F, 0x1E, comma,
// equals) take precedence over UTF-8 errors; else the first UTF-8 error in the field is reported.
module utf8_field_validator_top
    import ufv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       field_valid,
    output logic [2:0] error_code
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    ufv_state_t state_reg;
    ufv_state_t state_next;
    ufv_state_t step_state;
    logic [2:0] verdict;
    logic       can_load;
    logic       advance;
    logic       accept;

    assign advance       = s1_valid_reg && (!s1_end_reg || can_load);
    assign in_stall      = s1_valid_reg && !advance;
    assign accept        = in_valid && !in_stall;
    assign s1_valid_next = accept ? 1'b1 : (s1_valid_reg && !advance);
    assign state_next    = advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= STATE_CLEAR;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= is_end;
        end
    end

    ufv_decode u_decode (
        .state      (state_reg),
        .data_byte  (s1_byte_reg),
        .is_end     (s1_end_reg),
        .state_next (step_state),
        .verdict    (verdict)
    );

    ufv_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && s1_end_reg),
        .verdict     (verdict),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .field_valid (field_valid),
        .error_code  (error_code),
        .can_load    (can_load)
    );

    a_valid_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (field_valid == (error_code == ERR_NONE)))
        else $error("field_valid disagrees with error_code");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_end_reg) |=> (state_reg == STATE_CLEAR))
        else $error("field state not cleared after end item");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending != 2'd0) |->
            (state_reg.pending <= state_reg.seq_len && state_reg.utf_err == ERR_NONE))
        else $error("pending continuations inconsistent with sequence");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_end_reg && out_valid && out_stall))
        else $error("input stalled without a blocked verdict");

endmodule
